// File: rtl/mdte_pkg.sv
// Package with the shared types, codes and defaults of the Modbus data table engine.
`default_nettype none
package mdte_pkg;

  localparam int COIL_DEPTH_DEF     = 1024;
  localparam int DISCRETE_DEPTH_DEF = 1024;
  localparam int HOLDING_DEPTH_DEF  = 256;
  localparam int INREG_DEPTH_DEF    = 256;
  localparam int MAX_QUANTITY_DEF   = 64;

  // Address width on the memory command; covers two tables of the largest depth.
  localparam int ADDR_W = 18;

  localparam logic [3:0] ACT_READ_COIL      = 4'd0;
  localparam logic [3:0] ACT_READ_DISCRETE  = 4'd1;
  localparam logic [3:0] ACT_READ_HOLDING   = 4'd2;
  localparam logic [3:0] ACT_READ_INREG     = 4'd3;
  localparam logic [3:0] ACT_WRITE_COIL     = 4'd4;
  localparam logic [3:0] ACT_WRITE_DISCRETE = 4'd5;
  localparam logic [3:0] ACT_WRITE_HOLDING  = 4'd6;
  localparam logic [3:0] ACT_WRITE_INREG    = 4'd7;
  localparam logic [3:0] ACT_MASK_WRITE     = 4'd8;
  localparam logic [3:0] ACT_WRITE_READ     = 4'd9;

  localparam logic [1:0] TBL_COIL     = 2'd0;
  localparam logic [1:0] TBL_DISCRETE = 2'd1;
  localparam logic [1:0] TBL_HOLDING  = 2'd2;
  localparam logic [1:0] TBL_INREG    = 2'd3;

  localparam logic [2:0] CFG_COIL_BASE      = 3'd0;
  localparam logic [2:0] CFG_DISCRETE_BASE  = 3'd1;
  localparam logic [2:0] CFG_HOLDING_BASE   = 3'd2;
  localparam logic [2:0] CFG_INREG_BASE     = 3'd3;
  localparam logic [2:0] CFG_COIL_COUNT     = 3'd4;
  localparam logic [2:0] CFG_DISCRETE_COUNT = 3'd5;
  localparam logic [2:0] CFG_HOLDING_COUNT  = 3'd6;
  localparam logic [2:0] CFG_INREG_COUNT    = 3'd7;

  localparam logic         STATUS_OK      = 1'b0;
  localparam logic         STATUS_BAD_ADR = 1'b1;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] start_addr;
    logic [6:0]  quantity;
    logic [15:0] write_value;
    logic [15:0] keep_mask;
    logic [15:0] or_mask;
    logic [15:0] read_addr;
    logic [6:0]  read_quantity;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [15:0] read_value;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [15:0] coil_base;
    logic [15:0] discrete_base;
    logic [15:0] holding_base;
    logic [15:0] inreg_base;
    logic [10:0] coil_count;
    logic [10:0] discrete_count;
    logic [8:0]  holding_count;
    logic [8:0]  inreg_count;
  } cfg_t;

  typedef struct packed {
    logic              bit_we;
    logic              word_we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [15:0]       wdata;
  } mem_cmd_t;

endpackage
`default_nettype wire

// File: rtl/mdte_cfg.sv
// Configuration register file of the Modbus data table engine.
`default_nettype none
module mdte_cfg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  output mdte_pkg::cfg_t           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coil_base      <= 16'd0;
      cfg.discrete_base  <= 16'd0;
      cfg.holding_base   <= 16'd0;
      cfg.inreg_base     <= 16'd0;
      cfg.coil_count     <= 11'd1024;
      cfg.discrete_count <= 11'd1024;
      cfg.holding_count  <= 9'd256;
      cfg.inreg_count    <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mdte_pkg::CFG_COIL_BASE:      cfg.coil_base      <= cfg_data;
        mdte_pkg::CFG_DISCRETE_BASE:  cfg.discrete_base  <= cfg_data;
        mdte_pkg::CFG_HOLDING_BASE:   cfg.holding_base   <= cfg_data;
        mdte_pkg::CFG_INREG_BASE:     cfg.inreg_base     <= cfg_data;
        mdte_pkg::CFG_COIL_COUNT:     cfg.coil_count     <= cfg_data[10:0];
        mdte_pkg::CFG_DISCRETE_COUNT: cfg.discrete_count <= cfg_data[10:0];
        mdte_pkg::CFG_HOLDING_COUNT:  cfg.holding_count  <= cfg_data[8:0];
        mdte_pkg::CFG_INREG_COUNT:    cfg.inreg_count    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/mdte_mem.sv
// Bit and word table memories with the clearing pass that follows reset.
`default_nettype none
module mdte_mem #(
  parameter int BIT_DEPTH  = mdte_pkg::COIL_DEPTH_DEF + mdte_pkg::DISCRETE_DEPTH_DEF,
  parameter int WORD_DEPTH = mdte_pkg::HOLDING_DEPTH_DEF + mdte_pkg::INREG_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mdte_pkg::mem_cmd_t cmd,
  output logic                    bit_rdata,
  output logic [15:0]             word_rdata,
  output logic                    clearing
);

  localparam int BIT_AW  = $clog2(BIT_DEPTH);
  localparam int WORD_AW = $clog2(WORD_DEPTH);
  localparam int CLR_N   = (BIT_DEPTH > WORD_DEPTH) ? BIT_DEPTH : WORD_DEPTH;
  localparam int CLR_W   = $clog2(CLR_N);

  logic              bit_ram [BIT_DEPTH];
  logic [15:0]       word_ram [WORD_DEPTH];
  logic [CLR_W-1:0]  clr_cnt;

  logic               b_we;
  logic [BIT_AW-1:0]  b_addr;
  logic               b_data;
  logic               w_we;
  logic [WORD_AW-1:0] w_addr;
  logic [15:0]        w_data;

  always_comb begin
    if (clearing) begin
      b_we   = ({1'b0, clr_cnt} < (CLR_W + 1)'(BIT_DEPTH));
      b_addr = clr_cnt[BIT_AW-1:0];
      b_data = 1'b0;
      w_we   = ({1'b0, clr_cnt} < (CLR_W + 1)'(WORD_DEPTH));
      w_addr = clr_cnt[WORD_AW-1:0];
      w_data = 16'd0;
    end else begin
      b_we   = cmd.bit_we;
      b_addr = cmd.waddr[BIT_AW-1:0];
      b_data = (cmd.wdata != 16'd0);
      w_we   = cmd.word_we;
      w_addr = cmd.waddr[WORD_AW-1:0];
      w_data = cmd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + CLR_W'(1);
      if (clr_cnt == CLR_W'(CLR_N - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bit_ram[b_addr] <= b_data;
    end
    bit_rdata <= bit_ram[cmd.raddr[BIT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      word_ram[w_addr] <= w_data;
    end
    word_rdata <= word_ram[cmd.raddr[WORD_AW-1:0]];
  end

endmodule
`default_nettype wire

// File: rtl/mdte_ctrl.sv
// Request sequencer: range checks, read loops, element writes and mask writes.
`default_nettype none
module mdte_ctrl #(
  parameter int COIL_DEPTH     = mdte_pkg::COIL_DEPTH_DEF,
  parameter int DISCRETE_DEPTH = mdte_pkg::DISCRETE_DEPTH_DEF,
  parameter int HOLDING_DEPTH  = mdte_pkg::HOLDING_DEPTH_DEF,
  parameter int INREG_DEPTH    = mdte_pkg::INREG_DEPTH_DEF,
  parameter int MAX_QUANTITY   = mdte_pkg::MAX_QUANTITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire mdte_pkg::req_t     request,
  input  wire mdte_pkg::cfg_t     cfg,
  input  wire logic               bit_rdata,
  input  wire logic [15:0]        word_rdata,
  output mdte_pkg::mem_cmd_t      cmd,
  output logic                    active,
  output logic                    strobe,
  output mdte_pkg::rsp_t          result
);

  localparam int AW = mdte_pkg::ADDR_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_CHECK2  = 3'd2;
  localparam logic [2:0] S_EXEC    = 3'd3;
  localparam logic [2:0] S_MASK_WR = 3'd4;
  localparam logic [2:0] S_RDLOOP  = 3'd5;

  localparam logic [16:0] COIL_D     = 17'(COIL_DEPTH);
  localparam logic [16:0] DISCRETE_D = 17'(DISCRETE_DEPTH);
  localparam logic [16:0] HOLDING_D  = 17'(HOLDING_DEPTH);
  localparam logic [16:0] INREG_D    = 17'(INREG_DEPTH);
  localparam logic [6:0]  MAX_Q      = 7'(MAX_QUANTITY);

  logic [2:0]           state;
  mdte_pkg::req_t       item;
  logic                 wr_ok;
  logic [15:0]          wr_first;
  logic                 rd_ok;
  logic [15:0]          rd_first;
  logic [6:0]           pos;
  logic                 rejected;
  logic [AW-1:0]        rd_base;
  logic [6:0]           rd_k;
  logic [6:0]           rd_q;
  logic                 rd_bit;
  logic                 pend_vld;
  logic                 pend_last;
  logic                 pend_bit;

  logic                 is_read;
  logic                 is_mask;
  logic                 is_wtr;
  logic [1:0]           tbl;
  logic [1:0]           sp_tbl;
  logic [15:0]          sp_addr;
  logic [6:0]           sp_q;
  logic [15:0]          sp_base;
  logic [16:0]          sp_used;
  logic [15:0]          sp_first;
  logic                 sp_ok;
  logic [16:0]          wr_idx;
  logic                 wr_in_tbl;
  logic                 rej_eff;
  logic                 do_write;
  logic                 last_item;
  logic [AW-1:0]        wr_addr;
  logic [15:0]          mask_value;
  logic                 done_vld;
  mdte_pkg::rsp_t       done_rsp;
  mdte_pkg::rsp_t       pend_rsp;

  function automatic logic [16:0] used_of(input logic [1:0] t, input mdte_pkg::cfg_t c);
    logic [16:0] cnt;
    logic [16:0] depth;
    case (t)
      mdte_pkg::TBL_COIL:     begin cnt = 17'(c.coil_count);     depth = COIL_D;     end
      mdte_pkg::TBL_DISCRETE: begin cnt = 17'(c.discrete_count); depth = DISCRETE_D; end
      mdte_pkg::TBL_HOLDING:  begin cnt = 17'(c.holding_count);  depth = HOLDING_D;  end
      default:                begin cnt = 17'(c.inreg_count);    depth = INREG_D;    end
    endcase
    return (cnt > depth) ? depth : cnt;
  endfunction

  function automatic logic [15:0] base_of(input logic [1:0] t, input mdte_pkg::cfg_t c);
    case (t)
      mdte_pkg::TBL_COIL:     return c.coil_base;
      mdte_pkg::TBL_DISCRETE: return c.discrete_base;
      mdte_pkg::TBL_HOLDING:  return c.holding_base;
      default:                return c.inreg_base;
    endcase
  endfunction

  // Discrete inputs sit behind the coils, input registers behind the holding registers.
  function automatic logic [AW-1:0] offset_of(input logic [1:0] t);
    case (t)
      mdte_pkg::TBL_DISCRETE: return AW'(COIL_DEPTH);
      mdte_pkg::TBL_INREG:    return AW'(HOLDING_DEPTH);
      default:                return '0;
    endcase
  endfunction

  always_comb begin
    is_read = (item.action[3:2] == 2'b00);
    is_mask = (item.action == mdte_pkg::ACT_MASK_WRITE);
    is_wtr  = (item.action == mdte_pkg::ACT_WRITE_READ);
    tbl     = (is_mask || is_wtr) ? mdte_pkg::TBL_HOLDING : item.action[1:0];

    if (state == S_CHECK2) begin
      sp_tbl  = mdte_pkg::TBL_HOLDING;
      sp_addr = item.read_addr;
      sp_q    = item.read_quantity;
    end else begin
      sp_tbl  = tbl;
      sp_addr = item.start_addr;
      sp_q    = is_mask ? 7'd1 : item.quantity;
    end
    sp_base  = base_of(sp_tbl, cfg);
    sp_used  = used_of(sp_tbl, cfg);
    sp_first = sp_addr - sp_base;
    sp_ok    = (sp_q <= MAX_Q) && (sp_addr >= sp_base) &&
               (({1'b0, sp_first} + 17'(sp_q)) <= sp_used);

    wr_idx    = {1'b0, wr_first} + 17'(pos);
    wr_in_tbl = (wr_idx < used_of(tbl, cfg));
    rej_eff   = (pos == 7'd0) ? !(wr_ok && (!is_wtr || rd_ok)) : rejected;
    do_write  = !rej_eff && (item.quantity != 7'd0) && wr_ok && wr_in_tbl;
    last_item = (({1'b0, pos} + 8'd1) >= {1'b0, item.quantity});
    wr_addr   = offset_of(tbl) + AW'(wr_idx);

    mask_value = (word_rdata & item.keep_mask) | (item.or_mask & ~item.keep_mask);

    cmd.bit_we  = 1'b0;
    cmd.word_we = 1'b0;
    cmd.waddr   = wr_addr;
    cmd.wdata   = item.write_value;
    cmd.raddr   = (state == S_RDLOOP) ? (rd_base + AW'(rd_k)) : AW'(wr_first);
    if (state == S_EXEC && !is_read && !is_mask && do_write) begin
      cmd.bit_we  = !tbl[1];
      cmd.word_we = tbl[1];
    end else if (state == S_MASK_WR) begin
      cmd.word_we = 1'b1;
      cmd.waddr   = AW'(wr_first);
      cmd.wdata   = mask_value;
    end
  end

  always_comb begin
    done_vld            = 1'b0;
    done_rsp.status     = mdte_pkg::STATUS_OK;
    done_rsp.read_value = 16'd0;
    done_rsp.last       = 1'b1;
    if (state == S_EXEC) begin
      if (is_read || is_mask) begin
        if (!wr_ok) begin
          done_vld        = 1'b1;
          done_rsp.status = mdte_pkg::STATUS_BAD_ADR;
        end else if (!is_mask && item.quantity == 7'd0) begin
          done_vld = 1'b1;
        end
      end else if (last_item) begin
        if (rej_eff || (is_wtr && !rd_ok)) begin
          done_vld        = 1'b1;
          done_rsp.status = mdte_pkg::STATUS_BAD_ADR;
        end else if (!is_wtr || item.read_quantity == 7'd0) begin
          done_vld = 1'b1;
        end
      end
    end else if (state == S_MASK_WR) begin
      done_vld = 1'b1;
    end

    pend_rsp.status     = mdte_pkg::STATUS_OK;
    pend_rsp.read_value = pend_bit ? {15'd0, bit_rdata} : word_rdata;
    pend_rsp.last       = pend_last;
  end

  assign active = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pos      <= 7'd0;
      rejected <= 1'b0;
      pend_vld <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe   <= pend_vld | done_vld;
      result   <= done_vld ? done_rsp : pend_rsp;
      pend_vld <= (state == S_RDLOOP);

      unique case (state)
        S_IDLE: begin
          if (take) begin
            item <= request;
            if (request.action > mdte_pkg::ACT_WRITE_READ) begin
              pos      <= 7'd0;
              rejected <= 1'b0;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          wr_ok    <= sp_ok;
          wr_first <= sp_first;
          state    <= is_wtr ? S_CHECK2 : S_EXEC;
        end
        S_CHECK2: begin
          rd_ok    <= sp_ok;
          rd_first <= sp_first;
          state    <= S_EXEC;
        end
        S_EXEC: begin
          if (is_read || is_mask) begin
            pos      <= 7'd0;
            rejected <= 1'b0;
            if (wr_ok && is_mask) begin
              state <= S_MASK_WR;
            end else if (wr_ok && item.quantity != 7'd0) begin
              rd_base <= offset_of(tbl) + AW'(wr_first);
              rd_q    <= item.quantity;
              rd_bit  <= !tbl[1];
              rd_k    <= 7'd0;
              state   <= S_RDLOOP;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            rejected <= rej_eff;
            if (!last_item) begin
              pos   <= pos + 7'd1;
              state <= S_IDLE;
            end else begin
              pos <= 7'd0;
              if (!rej_eff && is_wtr && rd_ok && item.read_quantity != 7'd0) begin
                rd_base <= AW'(rd_first);
                rd_q    <= item.read_quantity;
                rd_bit  <= 1'b0;
                rd_k    <= 7'd0;
                state   <= S_RDLOOP;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        S_MASK_WR: begin
          state <= S_IDLE;
        end
        S_RDLOOP: begin
          pend_bit  <= rd_bit;
          pend_last <= ((rd_k + 7'd1) == rd_q);
          rd_k      <= rd_k + 7'd1;
          if ((rd_k + 7'd1) == rd_q) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/modbus_data_table_engine_core.sv
// Top level of the Modbus data table engine: coil, discrete, holding and input tables.
//
// After reset the block clears its tables and holds busy high until both table
// memories are cleared; configuration writes are taken during that pass. An item is
// taken when start is high and busy is low. A write element item passes the range
// check (a second one for write-then-read) and the decision step, which writes the
// element through the single write port of its table memory. A read of q elements
// delivers its q results on consecutive cycles, one element per cycle from the memory
// read port; a mask write is a read followed by a write of the same word.
// Every result appears on result for exactly one cycle with strobe high and cannot
// be held off, so the receiver must take it in that cycle.
`default_nettype none
module modbus_data_table_engine_core #(
  parameter int COIL_DEPTH     = mdte_pkg::COIL_DEPTH_DEF,
  parameter int DISCRETE_DEPTH = mdte_pkg::DISCRETE_DEPTH_DEF,
  parameter int HOLDING_DEPTH  = mdte_pkg::HOLDING_DEPTH_DEF,
  parameter int INREG_DEPTH    = mdte_pkg::INREG_DEPTH_DEF,
  parameter int MAX_QUANTITY   = mdte_pkg::MAX_QUANTITY_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire mdte_pkg::req_t  request,
  output logic                 strobe,
  output mdte_pkg::rsp_t       result,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [15:0]     cfg_data
);

  mdte_pkg::cfg_t     cfg;
  mdte_pkg::mem_cmd_t cmd;
  logic               bit_rdata;
  logic [15:0]        word_rdata;
  logic               clearing;
  logic               active;
  logic               take;

  assign busy = active | clearing;
  assign take = start & ~busy;

  mdte_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mdte_mem #(
    .BIT_DEPTH  (COIL_DEPTH + DISCRETE_DEPTH),
    .WORD_DEPTH (HOLDING_DEPTH + INREG_DEPTH)
  ) u_mem (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .bit_rdata  (bit_rdata),
    .word_rdata (word_rdata),
    .clearing   (clearing)
  );

  mdte_ctrl #(
    .COIL_DEPTH     (COIL_DEPTH),
    .DISCRETE_DEPTH (DISCRETE_DEPTH),
    .HOLDING_DEPTH  (HOLDING_DEPTH),
    .INREG_DEPTH    (INREG_DEPTH),
    .MAX_QUANTITY   (MAX_QUANTITY)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .request    (request),
    .cfg        (cfg),
    .bit_rdata  (bit_rdata),
    .word_rdata (word_rdata),
    .cmd        (cmd),
    .active     (active),
    .strobe     (strobe),
    .result     (result)
  );

endmodule
`default_nettype wire

// File: rtl/mdte_checker.sv
// Port-level checker of the Modbus data table engine and its bind to the top level.
`default_nettype none
module mdte_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            start,
  input wire logic            busy,
  input wire mdte_pkg::req_t  request,
  input wire logic            strobe,
  input wire mdte_pkg::rsp_t  result
);

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !strobe)
    else $error("result strobe seen right after reset");

  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset while tables are being cleared");

  a_reject_is_final: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status == mdte_pkg::STATUS_BAD_ADR) |->
      (result.last && result.read_value == 16'd0))
    else $error("rejected request result is not a final empty result");

  a_read_burst_dense: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |=> strobe)
    else $error("gap inside a read burst");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.action <= mdte_pkg::ACT_WRITE_READ) |=> busy)
    else $error("busy not raised after an item was taken");

endmodule

bind modbus_data_table_engine_core mdte_checker u_checker (.*);
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench of the Modbus data table engine, with its own model of the four tables.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mdte_pkg::*;

  localparam logic [3:0] ACT_UNUSED_LO = 4'd10;
  localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

  typedef struct packed {
    req_t req;
    logic typed;
    logic typed_status;
  } row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        request;
  logic        strobe;
  rsp_t        result;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        hint_valid;
  logic        hint_status;

  logic [15:0] tbl_base [0:3];
  logic [10:0] tbl_count [0:3];
  logic        coil_mem [0:COIL_DEPTH_DEF-1];
  logic        disc_mem [0:DISCRETE_DEPTH_DEF-1];
  logic [15:0] hold_mem [0:HOLDING_DEPTH_DEF-1];
  logic [15:0] inreg_mem [0:INREG_DEPTH_DEF-1];
  int unsigned write_pos;
  bit          write_rejected;
  rsp_t        awaited_rsp [$];
  int          n_errors;
  int          n_taken;
  bit          quiet_phase;
  row_t        plan [0:31];
  int          n_rows;

  modbus_data_table_engine_core u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .strobe(strobe),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned table_depth(logic [1:0] t);
    case (t)
      TBL_COIL:     return COIL_DEPTH_DEF;
      TBL_DISCRETE: return DISCRETE_DEPTH_DEF;
      TBL_HOLDING:  return HOLDING_DEPTH_DEF;
      default:      return INREG_DEPTH_DEF;
    endcase
  endfunction

  function automatic int unsigned span_limit(logic [1:0] t);
    int unsigned c;
    c = tbl_count[t];
    return (c > table_depth(t)) ? table_depth(t) : c;
  endfunction

  function automatic bit span_fits(logic [1:0] t, int unsigned addr, int unsigned q);
    if (q > MAX_QUANTITY_DEF || addr < tbl_base[t]) return 1'b0;
    return (addr - tbl_base[t]) + q <= span_limit(t);
  endfunction

  function automatic logic [15:0] peek_elem(logic [1:0] t, int unsigned i);
    if (i >= span_limit(t)) return 16'h0000;
    case (t)
      TBL_COIL:     return {15'h0, coil_mem[i]};
      TBL_DISCRETE: return {15'h0, disc_mem[i]};
      TBL_HOLDING:  return hold_mem[i];
      default:      return inreg_mem[i];
    endcase
  endfunction

  task automatic poke_elem(logic [1:0] t, int unsigned i, logic [15:0] v);
    if (i < span_limit(t)) begin
      case (t)
        TBL_COIL:     coil_mem[i] = (v != 16'h0000);
        TBL_DISCRETE: disc_mem[i] = (v != 16'h0000);
        TBL_HOLDING:  hold_mem[i] = v;
        default:      inreg_mem[i] = v;
      endcase
    end
  endtask

  task automatic queue_rsp(logic st, logic [15:0] v, logic lst);
    rsp_t r;
    r.status = st;
    r.read_value = v;
    r.last = lst;
    awaited_rsp.push_back(r);
  endtask

  task automatic predict_read(logic [1:0] t, int unsigned addr, int unsigned q);
    int unsigned k;
    if (!span_fits(t, addr, q)) begin
      queue_rsp(STATUS_BAD_ADR, 16'h0000, 1'b1);
    end else if (q == 0) begin
      queue_rsp(STATUS_OK, 16'h0000, 1'b1);
    end else begin
      for (k = 0; k < q; k++)
        queue_rsp(STATUS_OK, peek_elem(t, addr - tbl_base[t] + k), k + 1 == q);
    end
  endtask

  task automatic apply_request(req_t r);
    logic [1:0]  t;
    logic [15:0] old_word;
    int unsigned offs;
    if (r.action <= ACT_READ_INREG || r.action == ACT_MASK_WRITE ||
        r.action > ACT_WRITE_READ) begin
      write_pos = 0;
      write_rejected = 1'b0;
      if (r.action <= ACT_READ_INREG) begin
        predict_read(r.action[1:0], r.start_addr, r.quantity);
      end else if (r.action == ACT_MASK_WRITE) begin
        if (!span_fits(TBL_HOLDING, r.start_addr, 1)) begin
          queue_rsp(STATUS_BAD_ADR, 16'h0000, 1'b1);
        end else begin
          offs = r.start_addr - tbl_base[TBL_HOLDING];
          old_word = peek_elem(TBL_HOLDING, offs);
          poke_elem(TBL_HOLDING, offs,
                    (old_word & r.keep_mask) | (r.or_mask & ~r.keep_mask));
          queue_rsp(STATUS_OK, 16'h0000, 1'b1);
        end
      end
    end else begin
      t = (r.action == ACT_WRITE_READ) ? TBL_HOLDING : r.action[1:0];
      if (write_pos == 0) begin
        write_rejected = !span_fits(t, r.start_addr, r.quantity);
        if (r.action == ACT_WRITE_READ && !span_fits(TBL_HOLDING, r.read_addr, r.read_quantity))
          write_rejected = 1'b1;
      end
      if (!write_rejected && r.quantity > 0 && span_fits(t, r.start_addr, r.quantity))
        poke_elem(t, r.start_addr - tbl_base[t] + write_pos, r.write_value);
      if (write_pos + 1 < r.quantity) begin
        write_pos = (write_pos + 1) & 32'h7F;
      end else begin
        write_pos = 0;
        if (write_rejected) queue_rsp(STATUS_BAD_ADR, 16'h0000, 1'b1);
        else if (r.action != ACT_WRITE_READ) queue_rsp(STATUS_OK, 16'h0000, 1'b1);
        else predict_read(TBL_HOLDING, r.read_addr, r.read_quantity);
      end
    end
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    rsp_t typed_rsp;
    int   before_cnt;
    int   i;
    if (rst) begin
      for (i = 0; i < 4; i++) begin
        tbl_base[i] = 16'h0000;
        tbl_count[i] = 11'(table_depth(2'(i)));
      end
      for (i = 0; i < COIL_DEPTH_DEF; i++) coil_mem[i] = 1'b0;
      for (i = 0; i < DISCRETE_DEPTH_DEF; i++) disc_mem[i] = 1'b0;
      for (i = 0; i < HOLDING_DEPTH_DEF; i++) hold_mem[i] = 16'h0000;
      for (i = 0; i < INREG_DEPTH_DEF; i++) inreg_mem[i] = 16'h0000;
      write_pos = 0;
      write_rejected = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COIL_BASE:      tbl_base[TBL_COIL] = cfg_data;
          CFG_DISCRETE_BASE:  tbl_base[TBL_DISCRETE] = cfg_data;
          CFG_HOLDING_BASE:   tbl_base[TBL_HOLDING] = cfg_data;
          CFG_INREG_BASE:     tbl_base[TBL_INREG] = cfg_data;
          CFG_COIL_COUNT:     tbl_count[TBL_COIL] = cfg_data[10:0];
          CFG_DISCRETE_COUNT: tbl_count[TBL_DISCRETE] = cfg_data[10:0];
          CFG_HOLDING_COUNT:  tbl_count[TBL_HOLDING] = {2'b00, cfg_data[8:0]};
          default:            tbl_count[TBL_INREG] = {2'b00, cfg_data[8:0]};
        endcase
      end
      if (start && !busy) begin
        before_cnt = awaited_rsp.size();
        apply_request(request);
        if (hint_valid && awaited_rsp.size() == before_cnt + 1) begin
          typed_rsp.status = hint_status;
          typed_rsp.read_value = 16'h0000;
          typed_rsp.last = 1'b1;
          awaited_rsp[before_cnt] = typed_rsp;
        end
        n_taken++;
      end
      if (strobe) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t: result with nothing expected, actual status %b value %h last %b",
                   $time, result.status, result.read_value, result.last);
          n_errors++;
        end else begin
          want = awaited_rsp.pop_front();
          check_field("status", {15'h0, want.status}, {15'h0, result.status});
          check_field("read_value", want.read_value, result.read_value);
          check_field("last", {15'h0, want.last}, {15'h0, result.last});
        end
      end
    end
  end

  task automatic send_item(req_t r, logic typed, logic typed_st);
    int seen;
    seen = n_taken;
    start <= 1'b1;
    request <= r;
    hint_valid <= typed;
    hint_status <= typed_st;
    do @(negedge clk); while (n_taken == seen);
  endtask

  task automatic idle_gap();
    int n;
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet_phase || roll < 60) n = 0;
    else if (roll < 90) n = $urandom_range(1, 3);
    else if (roll < 98) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic put_reg(logic [2:0] idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
  endtask

  task automatic write_layout(logic [15:0] cb, logic [15:0] db, logic [15:0] hb,
                              logic [15:0] ib, logic [15:0] cc, logic [15:0] dc,
                              logic [15:0] hc, logic [15:0] ic);
    put_reg(CFG_COIL_BASE, cb);
    put_reg(CFG_DISCRETE_BASE, db);
    put_reg(CFG_HOLDING_BASE, hb);
    put_reg(CFG_INREG_BASE, ib);
    put_reg(CFG_COIL_COUNT, cc);
    put_reg(CFG_DISCRETE_COUNT, dc);
    put_reg(CFG_HOLDING_COUNT, hc);
    put_reg(CFG_INREG_COUNT, ic);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(logic [3:0] act, logic [15:0] sa, logic [6:0] q, logic [15:0] wv,
                         logic [15:0] am, logic [15:0] om, logic [15:0] ra, logic [6:0] rq,
                         logic typed, logic st);
    plan[n_rows].req.action = act;
    plan[n_rows].req.start_addr = sa;
    plan[n_rows].req.quantity = q;
    plan[n_rows].req.write_value = wv;
    plan[n_rows].req.keep_mask = am;
    plan[n_rows].req.or_mask = om;
    plan[n_rows].req.read_addr = ra;
    plan[n_rows].req.read_quantity = rq;
    plan[n_rows].typed = typed;
    plan[n_rows].typed_status = st;
    n_rows++;
  endtask

  function automatic req_t noise_req();
    req_t r;
    r.action = 4'($urandom);
    r.start_addr = 16'($urandom);
    r.quantity = 7'($urandom);
    r.write_value = 16'($urandom);
    r.keep_mask = 16'($urandom);
    r.or_mask = 16'($urandom);
    r.read_addr = 16'($urandom);
    r.read_quantity = 7'($urandom);
    return r;
  endfunction

  function automatic logic [15:0] pick_addr(logic [1:0] t);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 8) return tbl_base[t] + 16'($urandom_range(0, span_limit(t)));
    if (roll == 8) return tbl_base[t] - 16'd1;
    return 16'($urandom);
  endfunction

  function automatic logic [6:0] pick_qty();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 7'd0;
    if (roll < 68) return 7'($urandom_range(1, 4));
    if (roll < 85) return 7'($urandom_range(5, 16));
    if (roll < 95) return 7'($urandom_range(17, 64));
    return 7'($urandom_range(65, 127));
  endfunction

  task automatic run_traffic(int budget);
    req_t       r;
    logic [1:0] t;
    int         roll;
    int         k;
    int         n_elem;
    int         sent;
    sent = 0;
    while (sent < budget) begin
      r = noise_req();
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_item(r, 1'b0, STATUS_OK);
        idle_gap();
        if (r.action <= ACT_WRITE_READ) sent++;
      end else if (roll < 12) begin
        r.action = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        send_item(r, 1'b0, STATUS_OK);
        idle_gap();
      end else if (roll < 15) begin
        wait_drained();
      end else if (roll < 45) begin
        r.action = 4'($urandom_range(ACT_READ_COIL, ACT_READ_INREG));
        r.start_addr = pick_addr(r.action[1:0]);
        r.quantity = pick_qty();
        send_item(r, 1'b0, STATUS_OK);
        idle_gap();
        sent++;
      end else if (roll < 55) begin
        r.action = ACT_MASK_WRITE;
        r.start_addr = pick_addr(TBL_HOLDING);
        send_item(r, 1'b0, STATUS_OK);
        idle_gap();
        sent++;
      end else begin
        if ($urandom_range(0, 4) == 0) r.action = ACT_WRITE_READ;
        else r.action = 4'($urandom_range(ACT_WRITE_COIL, ACT_WRITE_INREG));
        t = (r.action == ACT_WRITE_READ) ? TBL_HOLDING : r.action[1:0];
        r.start_addr = pick_addr(t);
        r.quantity = pick_qty();
        r.read_addr = pick_addr(TBL_HOLDING);
        r.read_quantity = pick_qty();
        n_elem = (r.quantity == 0) ? 1 : r.quantity;
        if ($urandom_range(0, 9) == 0) n_elem = $urandom_range(1, n_elem);
        for (k = 0; k < n_elem; k++) begin
          r.write_value = 16'($urandom);
          r.keep_mask = 16'($urandom);
          r.or_mask = 16'($urandom);
          send_item(r, 1'b0, STATUS_OK);
          idle_gap();
          sent++;
        end
      end
    end
  endtask

  initial begin
    req_t r;
    int   i;
    int   phase;
    int   budget;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hint_valid = 1'b0;
    hint_status = STATUS_OK;
    quiet_phase = 1'b0;
    n_errors = 0;
    n_taken = 0;
    n_rows = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // The tables are still being cleared while these registers are written.
    write_layout(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 16'(COIL_DEPTH_DEF), 16'(DISCRETE_DEPTH_DEF), 16'(HOLDING_DEPTH_DEF),
                 16'(INREG_DEPTH_DEF));

    add_row(ACT_READ_COIL,      16'd0,     7'd1,   16'h0000, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b1, STATUS_OK);
    add_row(ACT_READ_DISCRETE,  16'd1023,  7'd1,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127,
            1'b1, STATUS_OK);
    add_row(ACT_READ_HOLDING,   16'd255,   7'd1,   16'h0000, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b1, STATUS_OK);
    add_row(ACT_READ_INREG,     16'd0,     7'd0,   16'h0000, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b1, STATUS_OK);
    add_row(ACT_READ_COIL,      16'd1024,  7'd1,   16'h0000, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b1, STATUS_BAD_ADR);
    add_row(ACT_READ_DISCRETE,  16'hFFFF,  7'd1,   16'h0000, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b1, STATUS_BAD_ADR);
    add_row(ACT_READ_HOLDING,   16'd0,     7'd65,  16'h0000, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b1, STATUS_BAD_ADR);
    add_row(ACT_WRITE_HOLDING,  16'd0,     7'd1,   16'hFFFF, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b1, STATUS_OK);
    add_row(ACT_WRITE_COIL,     16'd1021,  7'd3,   16'h0000, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b0, STATUS_OK);
    add_row(ACT_WRITE_COIL,     16'd1021,  7'd3,   16'h0005, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b0, STATUS_OK);
    add_row(ACT_WRITE_COIL,     16'd1021,  7'd3,   16'h0001, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b1, STATUS_OK);
    add_row(ACT_READ_COIL,      16'd1021,  7'd3,   16'h0000, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b0, STATUS_OK);
    add_row(ACT_WRITE_DISCRETE, 16'hFFFF,  7'd2,   16'h0001, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b0, STATUS_OK);
    add_row(ACT_WRITE_DISCRETE, 16'hFFFF,  7'd2,   16'h0001, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b1, STATUS_BAD_ADR);
    add_row(ACT_WRITE_INREG,    16'd5,     7'd0,   16'h1234, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b1, STATUS_OK);
    add_row(ACT_WRITE_INREG,    16'd255,   7'd1,   16'hA5A5, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b1, STATUS_OK);
    add_row(ACT_READ_INREG,     16'd192,   7'd64,  16'h0000, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b0, STATUS_OK);
    add_row(ACT_MASK_WRITE,     16'd0,     7'd1,   16'h0000, 16'h00FF, 16'h1234, 16'd0, 7'd0,
            1'b1, STATUS_OK);
    add_row(ACT_READ_HOLDING,   16'd0,     7'd1,   16'h0000, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b0, STATUS_OK);
    add_row(ACT_MASK_WRITE,     16'd256,   7'd1,   16'h0000, 16'hFFFF, 16'hFFFF, 16'd0, 7'd0,
            1'b1, STATUS_BAD_ADR);
    add_row(ACT_WRITE_READ,     16'd10,    7'd2,   16'h1111, 16'h0000, 16'h0000, 16'd9, 7'd4,
            1'b0, STATUS_OK);
    add_row(ACT_WRITE_READ,     16'd10,    7'd2,   16'h2222, 16'h0000, 16'h0000, 16'd9, 7'd4,
            1'b0, STATUS_OK);
    add_row(ACT_WRITE_READ,     16'd0,     7'd1,   16'hBEEF, 16'h0000, 16'h0000, 16'd0, 7'd127,
            1'b1, STATUS_BAD_ADR);
    add_row(ACT_WRITE_HOLDING,  16'd20,    7'd3,   16'h5A5A, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b0, STATUS_OK);
    add_row(ACT_READ_HOLDING,   16'd20,    7'd1,   16'h0000, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b0, STATUS_OK);
    add_row(ACT_UNUSED_HI,      16'd0,     7'd1,   16'h0000, 16'h0000, 16'h0000, 16'd0, 7'd0,
            1'b0, STATUS_OK);

    for (i = 0; i < n_rows; i++) begin
      send_item(plan[i].req, plan[i].typed, plan[i].typed_status);
      idle_gap();
    end
    wait_drained();

    for (phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: begin
          write_layout(16'h0100, 16'h8000, 16'h0040, 16'hC000, 16'd600, 16'd1024, 16'd200,
                       16'd256);
          budget = 130;
        end
        2: begin
          write_layout(16'hFFC0, 16'hFFFF, 16'hFF00, 16'hFFF0, 16'd2047, 16'd2047, 16'd511,
                       16'd511);
          budget = 60;
        end
        3: begin
          write_layout(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom & 32'hF800), 16'($urandom & 32'hF800),
                       16'($urandom & 32'hFE00), 16'($urandom & 32'hFE00));
          budget = 40;
        end
        4: begin
          write_layout(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom_range(1, 1100)), 16'($urandom_range(1, 1100)),
                       16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)));
          budget = 140;
        end
        default: begin
          write_layout(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                       16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)));
          budget = 90;
        end
      endcase
      quiet_phase = (phase == 2);
      run_traffic(budget);
      r = noise_req();
      r.action = ACT_READ_HOLDING;
      r.start_addr = tbl_base[TBL_HOLDING];
      r.quantity = 7'd1;
      send_item(r, 1'b0, STATUS_OK);
      wait_drained();
    end

    if (n_errors == 0 && awaited_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
